@@ rtl/stq_pkg.sv @@
// shared types and codes for the sorted task queue
`default_nettype none

package stq_pkg;

  // fixed widths of the input key fields and the configuration port
  localparam int KEY_IN_W  = 32;
  localparam int CFG_ID_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int STATUS_W  = 3;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

  // result status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_MISSING   = 3'd1;
  localparam status_t ST_PROTECTED = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_DUPLICATE = 3'd4;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // configuration register indexes
  localparam cfg_idx_t CFG_QUEUE_MODE     = 2'd0;
  localparam cfg_idx_t CFG_PROTECT_ENABLE = 2'd1;
  localparam cfg_idx_t CFG_PROTECTED_ID   = 2'd2;

endpackage

`default_nettype wire

@@ rtl/stq_if.sv @@
// valid/ready channel interfaces for the sorted task queue
`default_nettype none

interface stq_in_if #(
  parameter int ID_BITS = 8
);
  import stq_pkg::*;

  logic                opcode;
  logic [ID_BITS-1:0]  task_id;
  logic [KEY_IN_W-1:0] sort_key;
  logic [KEY_IN_W-1:0] current_ticks;
  logic                valid;
  logic                ready;

  modport source (output valid, opcode, task_id, sort_key, current_ticks, input ready);
  modport sink   (input valid, opcode, task_id, sort_key, current_ticks, output ready);
endinterface

interface stq_out_if #(
  parameter int ID_BITS  = 8,
  parameter int CNT_BITS = 5
);
  import stq_pkg::*;

  status_t             status;
  logic                head_valid;
  logic [ID_BITS-1:0]  head_id;
  logic [CNT_BITS-1:0] entry_count;
  logic                queue_emptied;
  logic                valid;
  logic                ready;

  modport source (output valid, status, head_valid, head_id, entry_count, queue_emptied,
                  input ready);
  modport sink   (input valid, status, head_valid, head_id, entry_count, queue_emptied,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/stq_ram.sv @@
// generic simple dual-port ram with registered read
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/sorted_task_queue.sv @@
// sorted task queue: ordered scheduler queue of task ids with insert and remove
//
// channels: in_chan carries one operation (insert or remove of a task id with
// its key and tick count), out_chan carries one result per operation (status,
// head of queue, entry count, emptied flag). both use valid/ready and a transfer
// happens on a rising edge with valid and ready high. cfg_wr_en/cfg_index/cfg_wdata
// write the mode and protection registers; the user must write them only while the
// block is idle, the block itself does not enforce it. entries live in one ram,
// kept in ascending key order. an operation (a refused remove apart) scans the
// queue one entry per cycle through the ram read port and a single id/key
// comparator, then, where needed, moves entries one slot per cycle to open or
// close a gap. in_chan.ready is high only in the idle state between operations,
// so a new operation is not taken before the last one is through. a finished
// result sits in the output register, so the next operation is taken while it
// waits; a second result waits until it is taken. reset (synchronous, rst_n low)
// empties the queue and clears the control, configuration and output valid
// registers; no clearing pass, entries beyond the count are never read.
`default_nettype none

module sorted_task_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int KEY_BITS    = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  stq_in_if.sink                 in_chan,
  stq_out_if.source              out_chan,
  input  wire logic              cfg_wr_en,
  input  wire stq_pkg::cfg_idx_t cfg_index,
  input  wire stq_pkg::cfg_dat_t cfg_wdata
);
  import stq_pkg::*;

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = ID_BITS + KEY_BITS;
  localparam int PID_W  = (ID_BITS > CFG_ID_W) ? ID_BITS : CFG_ID_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic                op_r, op_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                pend_r, pend_nxt;
  logic                more_r, more_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic                ins_set_r, ins_set_nxt;
  logic [CNT_W-1:0]    ins_pos_r, ins_pos_nxt;
  status_t             status_r, status_nxt;
  logic                emptied_r, emptied_nxt;
  logic [ID_BITS-1:0]  head_r, head_nxt;

  // configuration registers
  logic                mode_r, mode_nxt;
  logic                prot_en_r, prot_en_nxt;
  logic [CFG_ID_W-1:0] prot_id_r, prot_id_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic                out_head_valid_r, out_head_valid_nxt;
  logic [ID_BITS-1:0]  out_head_id_r, out_head_id_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_emptied_r, out_emptied_nxt;

  // ram port signals
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ENT_W-1:0]    rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENT_W-1:0]    wr_data;

  logic [ID_BITS-1:0]  rd_id;
  logic [KEY_BITS-1:0] rd_key;
  logic [CNT_W-1:0]    idx_inc, idx_dec, cmp_inc, cmp_dec, pos_inc;
  logic [KEY_IN_W:0]   key_sum;
  logic [KEY_BITS-1:0] new_key;
  logic                prot_hit;

  stq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_id   = rd_data[ENT_W-1 -: ID_BITS];
  assign rd_key  = rd_data[KEY_BITS-1:0];
  assign idx_inc = idx_r + ONE_CNT;
  assign idx_dec = idx_r - ONE_CNT;
  assign cmp_inc = cmp_idx_r + ONE_CNT;
  assign cmp_dec = cmp_idx_r - ONE_CNT;
  assign pos_inc = pos_r + ONE_CNT;

  // delay mode stores key + ticks, wrapping at the key width
  assign key_sum  = {1'b0, in_chan.sort_key} + {1'b0, in_chan.current_ticks};
  assign new_key  = mode_r ? KEY_BITS'(key_sum) : KEY_BITS'(in_chan.sort_key);
  assign prot_hit = prot_en_r && (PID_W'(in_chan.task_id) == PID_W'(prot_id_r));

  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt          = state_r;
    occ_nxt            = occ_r;
    op_nxt             = op_r;
    id_nxt             = id_r;
    key_nxt            = key_r;
    idx_nxt            = idx_r;
    cmp_idx_nxt        = cmp_idx_r;
    pend_nxt           = pend_r;
    more_nxt           = more_r;
    found_nxt          = found_r;
    pos_nxt            = pos_r;
    ins_set_nxt        = ins_set_r;
    ins_pos_nxt        = ins_pos_r;
    status_nxt         = status_r;
    emptied_nxt        = emptied_r;
    head_nxt           = head_r;
    mode_nxt           = mode_r;
    prot_en_nxt        = prot_en_r;
    prot_id_nxt        = prot_id_r;
    out_valid_nxt      = out_valid_r;
    out_status_nxt     = out_status_r;
    out_head_valid_nxt = out_head_valid_r;
    out_head_id_nxt    = out_head_id_r;
    out_count_nxt      = out_count_r;
    out_emptied_nxt    = out_emptied_r;
    rd_en              = 1'b0;
    rd_addr            = idx_r[ADDR_W-1:0];
    wr_en              = 1'b0;
    wr_addr            = ins_pos_r[ADDR_W-1:0];
    wr_data            = {id_r, key_r};

    // config writes; the user must write only while idle, the block does not enforce it
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_QUEUE_MODE:     mode_nxt    = cfg_wdata[0];
        CFG_PROTECT_ENABLE: prot_en_nxt = cfg_wdata[0];
        CFG_PROTECTED_ID:   prot_id_nxt = cfg_wdata[CFG_ID_W-1:0];
        default:            ;
      endcase
    end

    // result taken downstream
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt      = in_chan.opcode;
          id_nxt      = in_chan.task_id;
          key_nxt     = new_key;
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          found_nxt   = 1'b0;
          ins_set_nxt = 1'b0;
          ins_pos_nxt = occ_r;
          if (in_chan.opcode == OP_REMOVE && prot_hit) begin
            status_nxt  = ST_PROTECTED;
            emptied_nxt = 1'b0;
            state_nxt   = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // one entry read per cycle, compared in the cycle after its read
      S_SCAN: begin
        if (pend_r) begin
          if (!found_r && rd_id == id_r) begin
            found_nxt = 1'b1;
            pos_nxt   = cmp_idx_r;
          end
          // first key above the new one: insert goes in front of it
          if (!ins_set_r && rd_key > key_r) begin
            ins_set_nxt = 1'b1;
            ins_pos_nxt = cmp_idx_r;
          end
        end
        if (idx_r < occ_r) begin
          rd_en       = 1'b1;
          idx_nxt     = idx_inc;
          cmp_idx_nxt = idx_r;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (idx_r == occ_r && !pend_r) begin
          emptied_nxt = 1'b0;
          if (op_r == OP_INSERT) begin
            if (found_r) begin
              status_nxt = ST_DUPLICATE;
              state_nxt  = S_FINISH;
            end else if (occ_r == FULL_CNT) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FINISH;
            end else if (ins_pos_r == occ_r) begin
              state_nxt = S_PLACE;
            end else begin
              // move entries up, starting from the tail
              idx_nxt   = occ_r - ONE_CNT;
              more_nxt  = 1'b1;
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
          end else begin
            if (!found_r) begin
              status_nxt  = ST_MISSING;
              emptied_nxt = mode_r && (occ_r == '0);
              state_nxt   = S_FINISH;
            end else if (pos_inc == occ_r) begin
              // removed entry was the tail, nothing to move
              occ_nxt     = occ_r - ONE_CNT;
              status_nxt  = ST_OK;
              emptied_nxt = mode_r && (occ_r == ONE_CNT);
              state_nxt   = S_FINISH;
            end else begin
              idx_nxt   = pos_inc;
              more_nxt  = 1'b1;
              pend_nxt  = 1'b0;
              state_nxt = S_SHIFT;
            end
          end
        end
      end

      // read one slot, write it to its neighbor next cycle
      S_SHIFT: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = (op_r == OP_INSERT) ? cmp_inc[ADDR_W-1:0] : cmp_dec[ADDR_W-1:0];
          wr_data = rd_data;
          if (op_r == OP_REMOVE && cmp_dec == '0) begin
            head_nxt = rd_id;
          end
        end
        if (more_r) begin
          rd_en       = 1'b1;
          cmp_idx_nxt = idx_r;
          pend_nxt    = 1'b1;
          if (op_r == OP_INSERT) begin
            more_nxt = (idx_r != ins_pos_r);
            idx_nxt  = idx_dec;
          end else begin
            more_nxt = (idx_inc != occ_r);
            idx_nxt  = idx_inc;
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (!more_r && !pend_r) begin
          if (op_r == OP_INSERT) begin
            state_nxt = S_PLACE;
          end else begin
            occ_nxt     = occ_r - ONE_CNT;
            status_nxt  = ST_OK;
            emptied_nxt = mode_r && (occ_r == ONE_CNT);
            state_nxt   = S_FINISH;
          end
        end
      end

      // write the new entry into the opened slot
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = ins_pos_r[ADDR_W-1:0];
        wr_data = {id_r, key_r};
        if (ins_pos_r == '0) begin
          head_nxt = id_r;
        end
        occ_nxt     = occ_r + ONE_CNT;
        status_nxt  = ST_OK;
        emptied_nxt = 1'b0;
        state_nxt   = S_FINISH;
      end

      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = status_r;
          out_head_valid_nxt = (occ_r != '0);
          out_head_id_nxt    = (occ_r != '0) ? head_r : '0;
          out_count_nxt      = occ_r;
          out_emptied_nxt    = emptied_r;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      more_r      <= 1'b0;
      mode_r      <= 1'b0;
      prot_en_r   <= 1'b0;
      prot_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      more_r      <= more_nxt;
      mode_r      <= mode_nxt;
      prot_en_r   <= prot_en_nxt;
      prot_id_r   <= prot_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    id_r             <= id_nxt;
    key_r            <= key_nxt;
    idx_r            <= idx_nxt;
    cmp_idx_r        <= cmp_idx_nxt;
    found_r          <= found_nxt;
    pos_r            <= pos_nxt;
    ins_set_r        <= ins_set_nxt;
    ins_pos_r        <= ins_pos_nxt;
    status_r         <= status_nxt;
    emptied_r        <= emptied_nxt;
    head_r           <= head_nxt;
    out_status_r     <= out_status_nxt;
    out_head_valid_r <= out_head_valid_nxt;
    out_head_id_r    <= out_head_id_nxt;
    out_count_r      <= out_count_nxt;
    out_emptied_r    <= out_emptied_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.head_valid    = out_head_valid_r;
  assign out_chan.head_id       = out_head_id_r;
  assign out_chan.entry_count   = out_count_r;
  assign out_chan.queue_emptied = out_emptied_r;

endmodule

`default_nettype wire

@@ rtl/stq_chk.sv @@
// port-level checker for the sorted task queue and its bind
`default_nettype none

module stq_chk #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W       = 5
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire stq_pkg::status_t out_status,
  input wire logic             out_head_valid,
  input wire logic [CNT_W-1:0] out_count,
  input wire logic             out_emptied
);
  import stq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // a pending result is held until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= FULL_CNT)
    else $error("entry count above queue depth");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_head_valid == (out_count != '0))
    else $error("head valid disagrees with entry count");

  a_emptied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emptied |->
      out_count == '0 && (out_status == ST_OK || out_status == ST_MISSING))
    else $error("emptied flag with entries left or wrong status");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == FULL_CNT)
    else $error("full status on a queue that is not full");

endmodule

bind sorted_task_queue stq_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .CNT_W       ($clog2(QUEUE_DEPTH + 1))
) u_stq_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_head_valid (out_chan.head_valid),
  .out_count      (out_chan.entry_count),
  .out_emptied    (out_chan.queue_emptied)
);

`default_nettype wire
